@@ hdl/tcce_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console cursor engine: screen
// geometry, field widths, character codes and the result record.
// ----------------------------------------------------------------------------
package tcce_pkg;

  // screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;

  // field widths
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CELL_W = 11;
  localparam int BYTE_W = 8;
  localparam int PROD_W = ROW_W + COL_W + 1;

  // character codes
  localparam logic [BYTE_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_RETURN    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [BYTE_W-1:0] CH_BLANK     = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PRINT_LO  = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PRINT_HI  = 8'h7F;

  localparam logic [BYTE_W-1:0] ATTR_RESET = 8'h07;

  // command codes
  typedef enum logic {
    OP_PUT_CHAR = 1'b0,
    OP_CLEAR    = 1'b1
  } opcode_t;

  // result action codes
  typedef enum logic [1:0] {
    ACT_CURSOR = 2'd0,
    ACT_CELL   = 2'd1,
    ACT_ROW    = 2'd2,
    ACT_SCREEN = 2'd3
  } action_t;

  // one result beat
  typedef struct packed {
    action_t             action;
    logic [CELL_W-1:0]   cell_index;
    logic [BYTE_W-1:0]   glyph;
    logic [BYTE_W-1:0]   cell_attribute;
    logic [ROW_W-1:0]    cleared_row;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic                last;
  } result_t;

endpackage

@@ hdl/text_console_cursor_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_unit
// Teletype cursor engine for a character-cell screen: turns put-character and
// clear-screen commands into cell writes, row clears and screen clears.
// ----------------------------------------------------------------------------
// usage
//   in_*   : one command per beat (opcode, char_code), valid/ready
//   out_*  : one memory action per beat, valid/ready; out_last marks the
//            final beat of a command (a command gives one or two beats)
//   cfg_*  : write of the attribute byte; always ready, take it while idle
// timing
//   the cursor update and result build sit between the input handshake and
//   a four-entry result queue; each command's beats are written into the
//   queue on acceptance and reach out_* when they are at its head
//   one command per cycle while commands give one beat each and the receiver
//   takes every beat; a command that wraps past the bottom row with a cell
//   write fills two beats, and the single output port passes them one by one
// reset
//   cursor goes home, attribute returns to 0x07, the queue empties
// stall
//   while out_ready is low beats wait in the queue; in_ready drops once
//   fewer than two queue entries are free
// ----------------------------------------------------------------------------
module text_console_cursor_engine_unit
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_opcode,
  input  logic [BYTE_W-1:0] in_char_code,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_action,
  output logic [CELL_W-1:0] out_cell_index,
  output logic [BYTE_W-1:0] out_glyph,
  output logic [BYTE_W-1:0] out_cell_attribute,
  output logic [ROW_W-1:0]  out_cleared_row,
  output logic [COL_W-1:0]  out_cursor_column,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic              out_last,
  // attribute register write
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [BYTE_W-1:0] cfg_data
);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  // architectural state
  logic [COL_W-1:0]  column_pos_r, column_pos_nxt;
  logic [ROW_W-1:0]  row_pos_r, row_pos_nxt;
  logic [BYTE_W-1:0] attr_r;

  // result queue
  result_t           queue_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  logic in_fire, out_fire;

  // per-command results
  result_t res0, res1;
  logic    two_beats;

  // scratch for the cursor update
  logic [COL_W:0]     col_a;
  logic [ROW_W:0]     row_a;
  logic [COL_W-1:0]   wcol;
  logic [BYTE_W-1:0]  wglyph;
  logic               wrote;
  logic [PROD_W-1:0]  cell_sum;
  result_t            cell_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (count_r <= QCNT_W'(QDEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;

  // cell address of the written cell
  assign cell_sum = PROD_W'(row_pos_r) * PROD_W'(COLUMNS) + PROD_W'(wcol);

  always_comb begin
    col_a     = {1'b0, column_pos_r};
    row_a     = {1'b0, row_pos_r};
    wcol      = column_pos_r;
    wglyph    = '0;
    wrote     = 1'b0;
    two_beats = 1'b0;
    res0      = '0;
    res1      = '0;
    cell_res  = '0;

    // character handling
    if (in_char_code == CH_NEWLINE) begin
      row_a = row_a + 1'b1;
      col_a = '0;
    end else if (in_char_code == CH_RETURN) begin
      col_a = '0;
    end else if (in_char_code == CH_BACKSPACE) begin
      if (column_pos_r != '0) begin
        col_a  = col_a - 1'b1;
        wcol   = column_pos_r - 1'b1;
        wrote  = 1'b1;
        wglyph = CH_BLANK;
      end else if (row_pos_r != '0) begin
        row_a = row_a - 1'b1;
        col_a = (COL_W + 1)'(COLUMNS - 1);
      end
    end else if (in_char_code >= CH_PRINT_LO && in_char_code <= CH_PRINT_HI) begin
      wrote  = 1'b1;
      wglyph = in_char_code;
      col_a  = col_a + 1'b1;
    end

    // line wrap
    if (col_a >= (COL_W + 1)'(COLUMNS)) begin
      col_a = '0;
      row_a = row_a + 1'b1;
    end

    cell_res.action         = ACT_CELL;
    cell_res.cell_index     = CELL_W'(cell_sum);
    cell_res.glyph          = wglyph;
    cell_res.cell_attribute = attr_r;

    if (in_opcode == OP_CLEAR) begin
      // clear screen and home
      column_pos_nxt        = '0;
      row_pos_nxt           = '0;
      res0.action           = ACT_SCREEN;
      res0.glyph            = CH_BLANK;
      res0.cell_attribute   = attr_r;
      res0.last             = 1'b1;
    end else if (row_a >= (ROW_W + 1)'(ROWS)) begin
      // overflow past the bottom row: blank it and park the cursor
      column_pos_nxt = '0;
      row_pos_nxt    = ROW_W'(ROWS - 1);
      res1.action          = ACT_ROW;
      res1.glyph           = CH_BLANK;
      res1.cell_attribute  = attr_r;
      res1.cleared_row     = ROW_W'(ROWS - 1);
      res1.last            = 1'b1;
      if (wrote) begin
        two_beats  = 1'b1;
        res0       = cell_res;
        res0.last  = 1'b0;
      end else begin
        res0 = res1;
      end
    end else begin
      column_pos_nxt = COL_W'(col_a);
      row_pos_nxt    = ROW_W'(row_a);
      if (wrote) begin
        res0 = cell_res;
      end else begin
        res0.action = ACT_CURSOR;
      end
      res0.last = 1'b1;
    end

    // every beat reports the cursor after the command
    res0.cursor_column = column_pos_nxt;
    res0.cursor_row    = row_pos_nxt;
    res1.cursor_column = column_pos_nxt;
    res1.cursor_row    = row_pos_nxt;
  end

  // cursor and attribute registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_pos_r <= '0;
      row_pos_r    <= '0;
      attr_r       <= ATTR_RESET;
    end else begin
      if (in_fire) begin
        column_pos_r <= column_pos_nxt;
        row_pos_r    <= row_pos_nxt;
      end
      if (cfg_valid && cfg_ready) begin
        attr_r <= cfg_data;
      end
    end
  end

  // queue control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + (two_beats ? QPTR_W'(2) : QPTR_W'(1));
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r
               + (in_fire ? (two_beats ? QCNT_W'(2) : QCNT_W'(1)) : QCNT_W'(0))
               - (out_fire ? QCNT_W'(1) : QCNT_W'(0));
    end
  end

  // queue storage, payload only
  always_ff @(posedge clk) begin
    if (in_fire) begin
      queue_r[wr_ptr_r] <= res0;
      if (two_beats) begin
        queue_r[wr_ptr_r + 1'b1] <= res1;
      end
    end
  end

  // head of the queue drives the result beat
  assign out_action         = queue_r[rd_ptr_r].action;
  assign out_cell_index     = queue_r[rd_ptr_r].cell_index;
  assign out_glyph          = queue_r[rd_ptr_r].glyph;
  assign out_cell_attribute = queue_r[rd_ptr_r].cell_attribute;
  assign out_cleared_row    = queue_r[rd_ptr_r].cleared_row;
  assign out_cursor_column  = queue_r[rd_ptr_r].cursor_column;
  assign out_cursor_row     = queue_r[rd_ptr_r].cursor_row;
  assign out_last           = queue_r[rd_ptr_r].last;

endmodule

@@ hdl/tcce_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_checker
// Port-level checks of the cursor engine, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcce_checker
  import tcce_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        out_action,
  input logic [ROW_W-1:0]  out_cleared_row,
  input logic [COL_W-1:0]  out_cursor_column,
  input logic [ROW_W-1:0]  out_cursor_row,
  input logic              out_last
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action)
      && $stable(out_cursor_column) && $stable(out_cursor_row) && $stable(out_last))
    else $error("result beat changed while stalled");

  // cursor always on screen
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cursor_column < COL_W'(COLUMNS)) && (out_cursor_row < ROW_W'(ROWS)))
    else $error("cursor off screen");

  // a screen clear homes the cursor and ends the command
  a_screen_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_SCREEN |->
      out_cursor_column == '0 && out_cursor_row == '0 && out_last)
    else $error("screen clear without home cursor");

  // a row clear blanks the bottom row and parks the cursor there
  a_row_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_ROW |->
      out_cleared_row == ROW_W'(ROWS - 1) && out_cursor_row == ROW_W'(ROWS - 1)
      && out_cursor_column == '0 && out_last)
    else $error("row clear not on the bottom row");

  // a non-final cell write is followed at once by the bottom-row clear
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_action == ACT_ROW)
    else $error("missing row clear after cell write");

endmodule

bind text_console_cursor_engine_unit tcce_checker u_tcce_checker (.*);
